// ===== sv/audio_band_spectrum_tap_macros.svh =====
// assertion macros shared by the rtl files of the spectrum tap
// no dependencies; included by the modules that carry assertions
`ifndef AUDIO_BAND_SPECTRUM_TAP_MACROS_SVH
`define AUDIO_BAND_SPECTRUM_TAP_MACROS_SVH

// condition holds at every edge outside reset
`define ABST_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ABST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/abst_pkg.sv =====
// shared types, widths and constants of the spectrum tap
// no dependencies
`default_nettype none

package abst_pkg;

    localparam int BANDS_DEF       = 16;
    localparam int SCOPE_DEPTH_DEF = 256;
    localparam int DECIMATION_DEF  = 8;

    localparam int KIND_W       = 2;
    localparam int SAMPLE_W     = 16;
    localparam int BAND_IDX_W   = 4;
    localparam int SCOPE_BACK_W = 8;
    localparam int LEVEL_W      = 24;
    localparam int STAGE_W      = 25;
    localparam int ALPHA_W      = 16;

    // envelope fall and idle decay factors, q0.16
    localparam logic [12:0] FALL_Q16 = 13'd5243;
    localparam logic [15:0] IDLE_Q16 = 16'd39322;

    typedef enum logic [KIND_W-1:0] {
        KIND_AUDIO = 2'd0,
        KIND_BAND  = 2'd1,
        KIND_SCOPE = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_STORE,
        ST_DRAIN,
        ST_ENV,
        ST_AGE,
        ST_ADDR,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
    } t_bank_ctl;

    typedef struct packed {
        logic update;
        logic rotate;
        logic decay;
    } t_env_ctl;

    typedef struct packed {
        logic frame;
        logic age_load;
        logic age_step;
        logic addr;
        logic read;
    } t_scope_ctl;

endpackage

`default_nettype wire

// ===== sv/abst_item_if.sv =====
// input beat channel of the spectrum tap: valid/ready plus item fields
// depends on abst_pkg
`default_nettype none

interface abst_item_if import abst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                      chunk_start;
    logic [BAND_IDX_W-1:0]     band_index;
    logic [SCOPE_BACK_W-1:0]   scope_back;
    logic                      idle_decay;

    modport source (
        output valid, kind, left_sample, right_sample, chunk_start,
               band_index, scope_back, idle_decay,
        input  ready
    );
    modport sink (
        input  valid, kind, left_sample, right_sample, chunk_start,
               band_index, scope_back, idle_decay,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/abst_result_if.sv =====
// result beat channel of the spectrum tap: valid/ready plus result fields
// depends on abst_pkg
`default_nettype none

interface abst_result_if import abst_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [LEVEL_W-1:0]         band_level;
    logic signed [SAMPLE_W-1:0] scope_sample;

    modport source (
        output valid, band_level, scope_sample,
        input  ready
    );
    modport sink (
        input  valid, band_level, scope_sample,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/abst_bank.sv =====
// low-pass stage ring with a bit-serial alpha multiplier and alpha rom
// depends on abst_pkg
`default_nettype none

module abst_bank import abst_pkg::*; #(
    parameter int BANDS = BANDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_bank_ctl                  i_ctl,
    input  logic [$clog2(BANDS+1)-1:0] i_stage,
    input  logic signed [STAGE_W-1:0]  i_x,
    output logic [STAGE_W-1:0]         o_mag
);

    localparam int SW = $clog2(BANDS + 1);

    localparam logic [63:0] Q30_ONE    = 64'd1073741824;
    localparam logic [63:0] LN2_Q30    = 64'd744261118;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] RATE_HZ    = 64'd44100;
    localparam logic [63:0] BASE_HZ    = 64'd60;
    localparam logic [63:0] OCTAVES    = 64'd7;
    localparam logic [63:0] CAP_PCT    = 64'd45;

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + 64'd536870912) >> 30;
    endfunction

    // exp(x) or exp(-x), q30, twenty terms
    function automatic logic [63:0] exp_series(input logic [63:0] x, input logic neg);
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] m;
        t = Q30_ONE;
        p = Q30_ONE;
        m = 64'd0;
        t = mul_q30(t, x) / 64'd1;  if (neg) m = m + t; else p = p + t;
        t = mul_q30(t, x) / 64'd2;  p = p + t;
        t = mul_q30(t, x) / 64'd3;  if (neg) m = m + t; else p = p + t;
        t = mul_q30(t, x) / 64'd4;  p = p + t;
        t = mul_q30(t, x) / 64'd5;  if (neg) m = m + t; else p = p + t;
        t = mul_q30(t, x) / 64'd6;  p = p + t;
        t = mul_q30(t, x) / 64'd7;  if (neg) m = m + t; else p = p + t;
        t = mul_q30(t, x) / 64'd8;  p = p + t;
        t = mul_q30(t, x) / 64'd9;  if (neg) m = m + t; else p = p + t;
        t = mul_q30(t, x) / 64'd10; p = p + t;
        t = mul_q30(t, x) / 64'd11; if (neg) m = m + t; else p = p + t;
        t = mul_q30(t, x) / 64'd12; p = p + t;
        t = mul_q30(t, x) / 64'd13; if (neg) m = m + t; else p = p + t;
        t = mul_q30(t, x) / 64'd14; p = p + t;
        t = mul_q30(t, x) / 64'd15; if (neg) m = m + t; else p = p + t;
        t = mul_q30(t, x) / 64'd16; p = p + t;
        t = mul_q30(t, x) / 64'd17; if (neg) m = m + t; else p = p + t;
        t = mul_q30(t, x) / 64'd18; p = p + t;
        t = mul_q30(t, x) / 64'd19; if (neg) m = m + t; else p = p + t;
        t = mul_q30(t, x) / 64'd20; p = p + t;
        return (p > m) ? p - m : 64'd0;
    endfunction

    // alpha of one stage, q0.16, evaluated at elaboration only
    function automatic logic [ALPHA_W-1:0] alpha_of(input int unsigned b);
        logic [63:0] cap;
        logic [63:0] e7;
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] p;
        logic [63:0] fc;
        logic [63:0] w;
        logic [63:0] e;
        logic [63:0] a;
        cap   = ((RATE_HZ * CAP_PCT) << 16) / 64'd100;
        e7    = OCTAVES * 64'(b);
        whole = e7 / 64'(BANDS);
        frac  = LN2_Q30 * (e7 % 64'(BANDS)) / 64'(BANDS);
        p     = exp_series(frac, 1'b0);
        fc    = ((BASE_HZ * p) >> 14) << whole;
        if (fc > cap) fc = cap;
        w = (TWO_PI_Q30 * fc) / (RATE_HZ << 16);
        e = exp_series(w >> 3, 1'b1);
        e = mul_q30(e, e);
        e = mul_q30(e, e);
        e = mul_q30(e, e);
        if (e > Q30_ONE) e = Q30_ONE;
        a = (Q30_ONE - e + 64'd8192) >> 14;
        if (a > 64'd65535) a = 64'd65535;
        return a[ALPHA_W-1:0];
    endfunction

    logic [ALPHA_W-1:0] alpha_tab [BANDS+1];

    for (genvar g = 0; g <= BANDS; g++) begin : g_alpha
        localparam logic [ALPHA_W-1:0] ALPHA = alpha_of(g);
        assign alpha_tab[g] = ALPHA;
    end

    // stage ring, head is the stage being worked on
    logic signed [STAGE_W-1:0] r_lp [BANDS+1];
    logic signed [STAGE_W:0]   r_delta;
    logic signed [STAGE_W:0]   r_acc;
    logic [ALPHA_W-1:0]        r_alpha_sh;
    logic signed [STAGE_W-1:0] r_prev;
    logic signed [STAGE_W-1:0] r_last;
    logic [STAGE_W-1:0]        r_mag;

    logic signed [STAGE_W+1:0] acc_sum;
    logic signed [STAGE_W:0]   n_sum;
    logic signed [STAGE_W-1:0] n_lp;
    logic signed [STAGE_W:0]   diff;
    logic [STAGE_W:0]          diff_abs;

    // one alpha bit per step, halving keeps the floor exact
    assign acc_sum  = {r_acc[STAGE_W], r_acc}
                    + (r_alpha_sh[0] ? {r_delta[STAGE_W], r_delta} : '0);
    assign n_sum    = {r_lp[0][STAGE_W-1], r_lp[0]} + r_acc;
    assign n_lp     = n_sum[STAGE_W-1:0];
    assign diff     = {r_prev[STAGE_W-1], r_prev} - {r_last[STAGE_W-1], r_last};
    assign diff_abs = diff[STAGE_W] ? -diff : diff;
    assign o_mag    = r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= BANDS; i++) begin
                r_lp[i] <= '0;
            end
        end else if (i_ctl.store) begin
            for (int i = 0; i < BANDS; i++) begin
                r_lp[i] <= r_lp[i+1];
            end
            r_lp[BANDS] <= n_lp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_delta    <= {i_x[STAGE_W-1], i_x} - {r_lp[0][STAGE_W-1], r_lp[0]};
            r_alpha_sh <= alpha_tab[i_stage];
            r_acc      <= '0;
        end else if (i_ctl.step) begin
            r_acc      <= acc_sum[STAGE_W+1:1];
            r_alpha_sh <= r_alpha_sh >> 1;
        end
        if (i_ctl.store) begin
            r_last <= n_lp;
            r_prev <= r_last;
        end
        r_mag <= diff_abs[STAGE_W-1:0];
    end

endmodule

`default_nettype wire

// ===== sv/abst_env.sv =====
// band envelope ring: peak follower update and read pass with idle decay
// depends on abst_pkg
`default_nettype none

module abst_env import abst_pkg::*; #(
    parameter int BANDS = BANDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_env_ctl           i_ctl,
    input  logic [STAGE_W-1:0] i_mag,
    output logic [LEVEL_W-1:0] o_env_new
);

    logic [LEVEL_W-1:0] r_env [BANDS];

    logic [LEVEL_W-1:0] head;
    logic               rise;
    logic [STAGE_W-1:0] rise_diff;
    logic [STAGE_W-1:0] rise_val;
    logic [LEVEL_W-1:0] fall_diff;
    logic [36:0]        fall_prod;
    logic [39:0]        idle_prod;
    logic [LEVEL_W-1:0] n_env;

    assign head      = r_env[0];
    assign rise      = i_mag > {1'b0, head};
    assign rise_diff = i_mag - {1'b0, head};
    assign rise_val  = {1'b0, head} + {1'b0, rise_diff[STAGE_W-1:1]};
    assign fall_diff = head - i_mag[LEVEL_W-1:0];
    assign fall_prod = 37'(fall_diff) * 37'(FALL_Q16);
    assign idle_prod = 40'(head) * 40'(IDLE_Q16);

    always_comb begin
        priority if (i_ctl.update) begin
            n_env = rise ? rise_val[LEVEL_W-1:0]
                         : head - {3'b000, fall_prod[36:16]};
        end else if (i_ctl.decay) begin
            n_env = idle_prod[39:16];
        end else begin
            n_env = head;
        end
    end

    assign o_env_new = n_env;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BANDS; i++) begin
                r_env[i] <= '0;
            end
        end else if (i_ctl.update || i_ctl.rotate) begin
            for (int i = 0; i < BANDS - 1; i++) begin
                r_env[i] <= r_env[i+1];
            end
            r_env[BANDS-1] <= n_env;
        end
    end

endmodule

`default_nettype wire

// ===== sv/abst_scope.sv =====
// scope ring: group phase, held mean, write pointer and the scope memory
// depends on abst_pkg and audio_band_spectrum_tap_macros.svh
`default_nettype none
`include "audio_band_spectrum_tap_macros.svh"

module abst_scope import abst_pkg::*; #(
    parameter int SCOPE_DEPTH = SCOPE_DEPTH_DEF,
    parameter int DECIMATION  = DECIMATION_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_scope_ctl                 i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_left,
    input  logic signed [SAMPLE_W-1:0] i_right,
    input  logic                       i_chunk_start,
    input  logic [SCOPE_BACK_W-1:0]    i_scope_back,
    output logic                       o_age_ok,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    localparam int PTR_W = $clog2(SCOPE_DEPTH);
    localparam int PH_W  = $clog2(DECIMATION);
    localparam int AGE_W = (SCOPE_BACK_W > PTR_W + 1) ? SCOPE_BACK_W : PTR_W + 1;
    localparam logic [AGE_W-1:0] DEPTH_A   = AGE_W'(SCOPE_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_P   = (PTR_W + 1)'(SCOPE_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_M1  = (PTR_W + 1)'(SCOPE_DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(SCOPE_DEPTH - 1);
    localparam logic [PH_W-1:0]  PH_LAST   = PH_W'(DECIMATION - 1);

    logic [SAMPLE_W-1:0] r_mem [SCOPE_DEPTH];
    logic [PTR_W-1:0]    r_ptr;
    logic                r_filled;
    logic [PH_W-1:0]     r_phase;
    logic [SAMPLE_W-1:0] r_held;
    logic [AGE_W-1:0]    r_age;
    logic [PTR_W-1:0]    r_idx;
    logic                r_idx_ok;
    logic [SAMPLE_W-1:0] r_rdata;
    logic                r_rd_ok;

    logic [PH_W-1:0]     phase;
    logic [SAMPLE_W:0]   sum;
    logic [SAMPLE_W:0]   sum_adj;
    logic                do_write;
    logic [PTR_W:0]      idx_raw;
    logic [PTR_W:0]      idx_wrap;

    assign phase    = i_chunk_start ? '0 : r_phase;
    assign sum      = {i_left[SAMPLE_W-1], i_left} + {i_right[SAMPLE_W-1], i_right};
    // round toward zero: bias negatives by one before the halving
    assign sum_adj  = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};
    assign do_write = i_ctl.frame && (phase == PH_LAST);
    assign o_age_ok = r_age < DEPTH_A;
    assign idx_raw  = {1'b0, r_ptr} + (DEPTH_M1 - {1'b0, r_age[PTR_W-1:0]});
    assign idx_wrap = (idx_raw >= DEPTH_P) ? idx_raw - DEPTH_P : idx_raw;
    assign o_sample = r_rd_ok ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_filled <= 1'b0;
            r_phase  <= '0;
            r_held   <= '0;
        end else if (i_ctl.frame) begin
            if (phase == '0) begin
                r_held <= sum_adj[SAMPLE_W:1];
            end
            if (do_write) begin
                r_ptr <= (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                if (r_ptr == PTR_LAST) begin
                    r_filled <= 1'b1;
                end
            end
            r_phase <= (phase == PH_LAST) ? '0 : phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_ptr] <= r_held;
        end
        if (i_ctl.read) begin
            r_rdata <= r_mem[r_idx];
            r_rd_ok <= r_idx_ok;
        end
    end

    // age modulo depth by repeated subtraction, then pointer arithmetic
    always_ff @(posedge i_clk) begin
        if (i_ctl.age_load) begin
            r_age <= AGE_W'(i_scope_back);
        end else if (i_ctl.age_step && !o_age_ok) begin
            r_age <= r_age - DEPTH_A;
        end
        if (i_ctl.addr) begin
            r_idx    <= idx_wrap[PTR_W-1:0];
            r_idx_ok <= r_filled || (idx_wrap[PTR_W-1:0] < r_ptr);
        end
    end

    `ABST_ASSERT_ALWAYS(a_ptr_range, i_clk, i_rst_n, r_ptr <= PTR_LAST, "scope pointer out of range")
    `ABST_ASSERT_NEXT(a_ptr_moves, i_clk, i_rst_n, do_write, r_ptr != $past(r_ptr), "scope write did not advance pointer")
    `ABST_ASSERT_NEXT(a_filled_sticky, i_clk, i_rst_n, r_filled, r_filled, "scope fill mark dropped")

endmodule

`default_nettype wire

// ===== sv/audio_band_spectrum_tap.sv =====
// top level of the spectrum tap: sequencer, result register and the three units
// depends on abst_pkg, abst_item_if, abst_result_if, abst_bank, abst_env, abst_scope
`default_nettype none
`include "audio_band_spectrum_tap_macros.svh"

// Filter-bank spectrum and scope tap. Each beat on i_item is one item: an audio
// frame (kind 0), a band level read (kind 1, optionally after the idle decay of
// all envelopes), a scope read (kind 2) or nothing (kind 3). An audio frame is
// summed to x = (left + right) * 64 in q1.23 and pushed through BANDS+1 one-pole
// low-pass stages; each stage is one pass of a single bit-serial multiplier that
// takes one alpha bit per cycle, between a load and a store of the stage, and a
// drain state ends the frame. Band b's envelope follows |stage b - stage b+1|:
// after stage b+1 is stored, the magnitude is registered and the envelope is
// updated from it. A band read rotates the envelope ring once. A scope read
// reduces scope_back modulo SCOPE_DEPTH by repeated subtraction, then forms the
// address and reads the memory. Items are handled in order; kind 1 and 2 give
// one result beat each on o_result, held in an output register, so a new item
// is taken while a result still waits. i_item.ready is high whenever the
// sequencer is idle. The scope memory has no clearing pass: a fill mark makes
// never-written entries read as zero, so the block is ready right after reset.
module audio_band_spectrum_tap import abst_pkg::*; #(
    parameter int BANDS       = BANDS_DEF,
    parameter int SCOPE_DEPTH = SCOPE_DEPTH_DEF,
    parameter int DECIMATION  = DECIMATION_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    abst_item_if.sink      i_item,
    abst_result_if.source  o_result
);

    localparam int SW    = $clog2(BANDS + 1);
    localparam int BIT_W = $clog2(ALPHA_W);
    localparam int CMP_W = (SW > BAND_IDX_W) ? SW : BAND_IDX_W;
    localparam logic [BIT_W-1:0] BIT_LAST  = BIT_W'(ALPHA_W - 1);
    localparam logic [SW-1:0]    STAGE_END = SW'(BANDS);
    localparam logic [SW-1:0]    BAND_END  = SW'(BANDS - 1);

    // sequencer state
    t_state                     r_state;
    t_state                     n_state;
    logic [SW-1:0]              r_stage;
    logic [BIT_W-1:0]           r_bit;
    logic [1:0]                 r_pend;

    // item held while it is worked on
    logic signed [STAGE_W-1:0]  r_x;
    logic [BAND_IDX_W-1:0]      r_band;
    logic                       r_decay;
    logic                       r_is_scope;
    logic [LEVEL_W-1:0]         r_level;

    // result register
    logic                       r_out_valid;
    logic [LEVEL_W-1:0]         r_out_level;
    logic signed [SAMPLE_W-1:0] r_out_sample;

    logic                       accept;
    t_kind                      item_kind;
    logic [SAMPLE_W:0]          frame_sum;
    logic                       out_load;
    logic                       band_hit;
    logic                       age_ok;
    logic [STAGE_W-1:0]         mag;
    logic [LEVEL_W-1:0]         env_new;
    logic signed [SAMPLE_W-1:0] scope_sample;
    t_bank_ctl                  bank_ctl;
    t_env_ctl                   env_ctl;
    t_scope_ctl                 scope_ctl;

    assign accept    = i_item.valid && i_item.ready;
    assign item_kind = t_kind'(i_item.kind);
    assign frame_sum = {i_item.left_sample[SAMPLE_W-1], i_item.left_sample}
                     + {i_item.right_sample[SAMPLE_W-1], i_item.right_sample};
    assign band_hit  = CMP_W'(r_stage) == CMP_W'(r_band);

    assign i_item.ready          = (r_state == ST_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.band_level   = r_out_level;
    assign o_result.scope_sample = r_out_sample;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (item_kind)
                        KIND_AUDIO: n_state = ST_LOAD;
                        KIND_BAND:  n_state = ST_ENV;
                        KIND_SCOPE: n_state = ST_AGE;
                        KIND_NONE:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:  n_state = ST_MUL;
            ST_MUL: begin
                if (r_bit == BIT_LAST) n_state = ST_STORE;
            end
            ST_STORE: n_state = (r_stage == STAGE_END) ? ST_DRAIN : ST_LOAD;
            // last envelope update still in flight
            ST_DRAIN: begin
                if (r_pend == '0) n_state = ST_IDLE;
            end
            ST_ENV: begin
                if (r_stage == BAND_END) n_state = ST_DONE;
            end
            ST_AGE: begin
                if (age_ok) n_state = ST_ADDR;
            end
            ST_ADDR:  n_state = ST_READ;
            ST_READ:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // unit controls
    always_comb begin
        bank_ctl.load     = (r_state == ST_LOAD);
        bank_ctl.step     = (r_state == ST_MUL);
        bank_ctl.store    = (r_state == ST_STORE);
        env_ctl.update    = r_pend[1];
        env_ctl.rotate    = (r_state == ST_ENV);
        env_ctl.decay     = r_decay;
        scope_ctl.frame   = accept && (item_kind == KIND_AUDIO);
        scope_ctl.age_load = accept && (item_kind == KIND_SCOPE);
        scope_ctl.age_step = (r_state == ST_AGE);
        scope_ctl.addr    = (r_state == ST_ADDR);
        scope_ctl.read    = (r_state == ST_READ);
        out_load          = (r_state == ST_DONE) && (!r_out_valid || o_result.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stage     <= '0;
            r_bit       <= '0;
            r_pend      <= '0;
            r_decay     <= 1'b0;
            r_is_scope  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // envelope update of band b-1 is delayed through r_pend once stage b is stored
            r_pend  <= {r_pend[0], bank_ctl.store && (r_stage != '0)};
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_stage    <= '0;
                r_decay    <= i_item.idle_decay && (item_kind == KIND_BAND);
                r_is_scope <= (item_kind == KIND_SCOPE);
            end else if (bank_ctl.store || env_ctl.rotate) begin
                r_stage <= r_stage + 1'b1;
            end
            if (bank_ctl.load) begin
                r_bit <= '0;
            end else if (bank_ctl.step) begin
                r_bit <= r_bit + 1'b1;
            end
        end
    end

    // item payload and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x     <= {{2{frame_sum[SAMPLE_W]}}, frame_sum, 6'b000000};
            r_band  <= i_item.band_index;
            r_level <= '0;
        end else if (env_ctl.rotate && band_hit) begin
            r_level <= env_new;
        end
        if (out_load) begin
            r_out_level  <= r_is_scope ? '0 : r_level;
            r_out_sample <= r_is_scope ? scope_sample : '0;
        end
    end

    abst_bank #(
        .BANDS(BANDS)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (bank_ctl),
        .i_stage (r_stage),
        .i_x     (r_x),
        .o_mag   (mag)
    );

    abst_env #(
        .BANDS(BANDS)
    ) u_env (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (env_ctl),
        .i_mag     (mag),
        .o_env_new (env_new)
    );

    abst_scope #(
        .SCOPE_DEPTH(SCOPE_DEPTH),
        .DECIMATION (DECIMATION)
    ) u_scope (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scope_ctl),
        .i_left        (i_item.left_sample),
        .i_right       (i_item.right_sample),
        .i_chunk_start (i_item.chunk_start),
        .i_scope_back  (i_item.scope_back),
        .o_age_ok      (age_ok),
        .o_sample      (scope_sample)
    );

    `ABST_ASSERT_ALWAYS(a_env_excl, i_clk, i_rst_n, !(env_ctl.update && env_ctl.rotate), "envelope update during read pass")
    `ABST_ASSERT_NEXT(a_frame_start, i_clk, i_rst_n, scope_ctl.frame, (r_state == ST_LOAD) && (r_stage == '0), "frame did not start at stage zero")
    `ABST_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, out_load, r_out_valid && (r_state == ST_IDLE), "result not registered")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench of audio_band_spectrum_tap: random and directed items, in-order checks
// depends on abst_pkg, abst_item_if, abst_result_if and the rtl of the spectrum tap
`default_nettype none

module tb;
    import abst_pkg::*;

    localparam int NB        = BANDS_DEF;
    localparam int SD        = SCOPE_DEPTH_DEF;
    localparam int DEC       = DECIMATION_DEF;
    localparam int QUIET_MAX = 4000;
    localparam int DRAIN     = 400;
    localparam int RANDOM_N  = 730;

    typedef struct {
        t_kind                      kind;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       chunk_start;
        logic [BAND_IDX_W-1:0]      band_index;
        logic [SCOPE_BACK_W-1:0]    scope_back;
        logic                       idle_decay;
    } tap_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]         level;
        logic signed [SAMPLE_W-1:0] sample;
    } readout_t;

    // clock and one reset at the start
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    abst_item_if   item_ch ();
    abst_result_if result_ch ();

    audio_band_spectrum_tap uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // everything the testbench drives starts at a known value
    logic                       drv_valid  = 1'b0;
    t_kind                      drv_kind   = KIND_NONE;
    logic signed [SAMPLE_W-1:0] drv_left   = '0;
    logic signed [SAMPLE_W-1:0] drv_right  = '0;
    logic                       drv_chunk  = 1'b0;
    logic [BAND_IDX_W-1:0]      drv_band   = '0;
    logic [SCOPE_BACK_W-1:0]    drv_back   = '0;
    logic                       drv_idle   = 1'b0;
    logic                       drv_ready  = 1'b0;

    assign item_ch.valid        = drv_valid;
    assign item_ch.kind         = drv_kind;
    assign item_ch.left_sample  = drv_left;
    assign item_ch.right_sample = drv_right;
    assign item_ch.chunk_start  = drv_chunk;
    assign item_ch.band_index   = drv_band;
    assign item_ch.scope_back   = drv_back;
    assign item_ch.idle_decay   = drv_idle;
    assign result_ch.ready      = drv_ready;

    // ------------------------------------------------------------------
    // predictor state: filter bank, envelopes, scope ring, group phase
    // ------------------------------------------------------------------
    int          alpha_q16 [NB+1];
    int          lp_state  [NB+1];
    logic [31:0] env_level [NB];
    logic signed [SAMPLE_W-1:0] scope_mem [SD];
    int          scope_wr    = 0;
    int          group_phase = 0;
    int          group_mean  = 0;

    tap_item_t item_backlog [$];
    readout_t  readouts     [$];

    int  items_queued   = 0;
    int  items_accepted = 0;
    int  mismatches     = 0;
    int  quiet_cycles   = 0;
    logic in_taken  = 1'b0;
    logic res_taken = 1'b0;

    // q30 helpers for the alpha table
    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned q30_exp(longint unsigned x, bit neg);
        longint unsigned term, pos, nsum;
        term = 64'd1 << 30;
        pos  = 64'd1 << 30;
        nsum = 0;
        for (int n = 1; n <= 20; n++) begin
            term = q30_mul(term, x) / n;
            if (neg && (n % 2 == 1))
                nsum += term;
            else
                pos += term;
        end
        return (pos > nsum) ? pos - nsum : 64'd0;
    endfunction

    // cutoff per stage: 60 Hz * 2^(7b/bands), capped at 0.45 of the rate
    function automatic void build_alpha_table();
        longint unsigned cap, frac, p, fc, w, e, a;
        int e7, whole;
        cap = ((64'd44100 * 64'd45) << 16) / 64'd100;
        for (int b = 0; b <= NB; b++) begin
            e7    = 7 * b;
            whole = e7 / NB;
            frac  = 64'd744261118 * longint'(e7 % NB) / longint'(NB);
            p     = q30_exp(frac, 1'b0);
            fc    = ((64'd60 * p) >> 14) << whole;
            if (fc > cap)
                fc = cap;
            w = (64'd6746518852 * fc) / (64'd44100 << 16);
            e = q30_exp(w >> 3, 1'b1);
            for (int k = 0; k < 3; k++)
                e = q30_mul(e, e);
            if (e > (64'd1 << 30))
                e = 64'd1 << 30;
            a = ((64'd1 << 30) - e + (64'd1 << 13)) >> 14;
            if (a > 64'd65535)
                a = 64'd65535;
            alpha_q16[b] = int'(a);
        end
    endfunction

    // advance the predicted block by one accepted item, returns 1 when a readout follows
    function automatic bit spectrum_apply_item(input tap_item_t it, output readout_t ro);
        int              x, d, slot;
        longint          delta;
        longint unsigned mag, env;
        ro = '0;
        case (it.kind)
            KIND_AUDIO: begin
                x = (int'(it.left_sample) + int'(it.right_sample)) * 64;
                for (int b = 0; b <= NB; b++) begin
                    delta = longint'(x) - longint'(lp_state[b]);
                    lp_state[b] += int'((longint'(alpha_q16[b]) * delta) >>> 16);
                end
                for (int b = 0; b < NB; b++) begin
                    d   = lp_state[b] - lp_state[b+1];
                    mag = (d < 0) ? longint'(-d) : longint'(d);
                    env = longint'(env_level[b]);
                    if (mag > env)
                        env += (mag - env) >> 1;
                    else
                        env -= ((env - mag) * longint'(FALL_Q16)) >> 16;
                    env_level[b] = 32'(env & 64'hFF_FFFF);
                end
                // group of frames: remember the first, store it once the group completes
                if (it.chunk_start)
                    group_phase = 0;
                if (group_phase == 0)
                    group_mean = (int'(it.left_sample) + int'(it.right_sample)) / 2;
                if (group_phase == DEC - 1) begin
                    scope_mem[scope_wr] = group_mean[SAMPLE_W-1:0];
                    scope_wr = (scope_wr + 1) % SD;
                end
                group_phase = (group_phase + 1) % DEC;
                return 1'b0;
            end
            KIND_BAND: begin
                if (it.idle_decay) begin
                    for (int b = 0; b < NB; b++)
                        env_level[b] = 32'((longint'(env_level[b]) * longint'(IDLE_Q16)) >> 16);
                end
                if (int'(it.band_index) < NB)
                    ro.level = env_level[it.band_index][LEVEL_W-1:0];
                return 1'b1;
            end
            KIND_SCOPE: begin
                slot = (scope_wr + SD - 1 - (int'(it.scope_back) % SD)) % SD;
                ro.sample = scope_mem[slot];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatches < 40)
            $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // monitor: sample both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        tap_item_t it;
        readout_t  ro, want;
        bit        fires;
        in_taken  <= i_rst_n && item_ch.valid && item_ch.ready;
        res_taken <= i_rst_n && result_ch.valid && result_ch.ready;
        if (i_rst_n) begin
            fires = 1'b0;
            if (item_ch.valid && item_ch.ready) begin
                it.kind         = t_kind'(item_ch.kind);
                it.left_sample  = item_ch.left_sample;
                it.right_sample = item_ch.right_sample;
                it.chunk_start  = item_ch.chunk_start;
                it.band_index   = item_ch.band_index;
                it.scope_back   = item_ch.scope_back;
                it.idle_decay   = item_ch.idle_decay;
                if (spectrum_apply_item(it, ro))
                    readouts.push_back(ro);
                items_accepted <= items_accepted + 1;
                fires = 1'b1;
            end
            if (result_ch.valid && result_ch.ready) begin
                fires = 1'b1;
                if (readouts.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding",
                                    longint'(result_ch.band_level),
                                    longint'(result_ch.scope_sample));
                end else begin
                    want = readouts.pop_front();
                    if (result_ch.band_level !== want.level)
                        report_mismatch("band_level", longint'(result_ch.band_level),
                                        longint'(want.level));
                    if (result_ch.scope_sample !== want.sample)
                        report_mismatch("scope_sample", longint'(result_ch.scope_sample),
                                        longint'(want.sample));
                end
            end
            // watchdog on cycles with no beat on either channel
            if (fires)
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_MAX) begin
                $display("tb: failure");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // idle length for one item or result, zero throughout calm stretches
    function automatic int wait_draw(bit calm);
        return calm ? 0 : int'($urandom_range(0, 7));
    endfunction

    // ------------------------------------------------------------------
    // driver: next item at the falling edge once the current one is taken
    // ------------------------------------------------------------------
    int send_gap  = 0;
    bit send_calm = 1'b0;

    always @(negedge i_clk) begin
        tap_item_t nxt;
        if (!i_rst_n)
            drv_valid <= 1'b0;
        else if (!drv_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap  <= send_gap - 1;
                drv_valid <= 1'b0;
            end else if (item_backlog.size() != 0) begin
                nxt = item_backlog.pop_front();
                drv_kind  <= nxt.kind;
                drv_left  <= nxt.left_sample;
                drv_right <= nxt.right_sample;
                drv_chunk <= nxt.chunk_start;
                drv_band  <= nxt.band_index;
                drv_back  <= nxt.scope_back;
                drv_idle  <= nxt.idle_decay;
                drv_valid <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    send_calm = !send_calm;
                send_gap <= wait_draw(send_calm);
            end else
                drv_valid <= 1'b0;
        end
    end

    // receiver: random stall after each result, plus random drops between results outside calm stretches
    int recv_stall = 0;
    bit recv_calm  = 1'b0;

    always @(negedge i_clk) begin
        int stall;
        if (!i_rst_n)
            drv_ready <= 1'b0;
        else if (res_taken) begin
            if ($urandom_range(0, 31) == 0)
                recv_calm = !recv_calm;
            stall = wait_draw(recv_calm);
            recv_stall <= stall;
            drv_ready  <= (stall == 0);
        end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            drv_ready  <= (recv_stall == 1);
        end else
            drv_ready <= recv_calm ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_item(t_kind k, int l, int r, bit cs, int band, int back, bit idle);
        tap_item_t it;
        it.kind         = k;
        it.left_sample  = l[SAMPLE_W-1:0];
        it.right_sample = r[SAMPLE_W-1:0];
        it.chunk_start  = cs;
        it.band_index   = band[BAND_IDX_W-1:0];
        it.scope_back   = back[SCOPE_BACK_W-1:0];
        it.idle_decay   = idle;
        item_backlog.push_back(it);
        items_queued++;
    endtask

    // full-scale corners, small values near zero, or anything
    function automatic int pick_sample();
        case ($urandom_range(0, 5))
            0:       return 32767;
            1:       return -32768;
            2:       return int'($urandom_range(0, 15)) - 8;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    initial begin
        int pick;
        build_alpha_table();
        for (int b = 0; b <= NB; b++)
            lp_state[b] = 0;
        for (int b = 0; b < NB; b++)
            env_level[b] = '0;
        for (int s = 0; s < SD; s++)
            scope_mem[s] = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reads straight after reset, idle decay on empty envelopes
        push_item(KIND_BAND, 0, 0, 1'b0, 0, 0, 1'b1);
        push_item(KIND_SCOPE, 0, 0, 1'b0, 0, 0, 1'b0);
        // oldest entry, idle flag on a scope read is ignored
        push_item(KIND_SCOPE, -1, -1, 1'b1, 15, 255, 1'b1);
        // unused kind with every field busy
        push_item(KIND_NONE, 32767, -32768, 1'b1, 9, 128, 1'b1);
        // a short group cut off by the next chunk start writes nothing
        push_item(KIND_AUDIO, 32767, 32767, 1'b1, 0, 0, 1'b0);
        push_item(KIND_AUDIO, -32768, -32768, 1'b0, 0, 0, 1'b0);
        push_item(KIND_AUDIO, -32768, 32767, 1'b0, 0, 0, 1'b1);
        // full group from a chunk start, full-scale square wave
        push_item(KIND_AUDIO, 32767, 32767, 1'b1, 0, 0, 1'b0);
        for (int f = 1; f < DEC; f++) begin
            if (f % 2 == 1)
                push_item(KIND_AUDIO, -32768, -32768, 1'b0, 15, 255, 1'b0);
            else
                push_item(KIND_AUDIO, 32767, 32767, 1'b0, 0, 0, 1'b0);
        end
        push_item(KIND_SCOPE, 0, 0, 1'b0, 0, 0, 1'b0);
        push_item(KIND_BAND, 0, 0, 1'b0, 15, 0, 1'b0);
        push_item(KIND_BAND, 0, 0, 1'b0, 7, 0, 1'b1);
        push_item(KIND_BAND, 0, 0, 1'b0, 0, 0, 1'b0);
        push_item(KIND_SCOPE, 0, 0, 1'b0, 0, 1, 1'b0);

        // hold the sender until every outstanding result is back
        while (items_accepted != items_queued || readouts.size() != 0)
            @(negedge i_clk);

        // random part: mostly frames, with occasional chunk starts that cut groups short
        for (int n = 0; n < RANDOM_N; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                push_item(KIND_AUDIO, pick_sample(), pick_sample(),
                          ($urandom_range(0, 23) == 0), $urandom_range(0, 15),
                          $urandom_range(0, 255), $urandom_range(0, 1));
            else if (pick < 82)
                push_item(KIND_BAND, pick_sample(), pick_sample(), $urandom_range(0, 1),
                          $urandom_range(0, 15), $urandom_range(0, 255),
                          ($urandom_range(0, 3) == 0));
            else if (pick < 95)
                push_item(KIND_SCOPE, pick_sample(), pick_sample(), $urandom_range(0, 1),
                          $urandom_range(0, 15),
                          $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255),
                          $urandom_range(0, 1));
            else
                push_item(KIND_NONE, pick_sample(), pick_sample(), $urandom_range(0, 1),
                          $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 1));
        end

        // wait for the last beats, then let a trailing frame finish
        while (items_accepted != items_queued || readouts.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        if (readouts.size() != 0)
            report_mismatch("results never delivered", longint'(readouts.size()), 0);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/abst_pkg.sv
sv/abst_item_if.sv
sv/abst_result_if.sv
sv/abst_bank.sv
sv/abst_env.sv
sv/abst_scope.sv
sv/audio_band_spectrum_tap.sv
verif/tb.sv
